@@ hw/rtl/buddy_block_allocator_unit_macros.svh @@
// Assertion macros used by the checker file of the buddy block allocator.
`ifndef BUDDY_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and ignored while rst_n is low.
`define BBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and ignored while rst_n is low.
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/bba_pkg.sv @@
// Package with the types, constants and helper functions of the buddy block allocator.
package bba_pkg;

  localparam int MAX_UNITS  = 1024;
  localparam int MAX_LG     = $clog2(MAX_UNITS);
  localparam int CAP_W      = 11;
  localparam int OFF_W      = 10;
  localparam int STATUS_W   = 2;
  localparam int LVL_W      = 4;
  localparam int NODE_AW    = MAX_LG + 1;
  localparam int NODE_DEPTH = 2 ** NODE_AW;
  localparam int PROD_W     = NODE_AW + MAX_LG;

  // Two-bit state of one tree node.
  typedef enum logic [1:0] {
    ND_UNUSED = 2'd0,
    ND_USED   = 2'd1,
    ND_SPLIT  = 2'd2,
    ND_FULL   = 2'd3
  } node_st_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_t;

  // Request operation codes.
  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    CS_CLEAR,
    CS_IDLE,
    CS_A_EVAL,
    CS_A_SPLIT_L,
    CS_A_SPLIT_R,
    CS_A_UP,
    CS_A_MARK,
    CS_F_EVAL,
    CS_F_MERGE,
    CS_F_UP,
    CS_DONE
  } ctl_state_t;

  // Access to the node memory: write enable, write address and data, read address.
  typedef struct packed {
    logic               we;
    logic [NODE_AW-1:0] waddr;
    node_st_t           wdata;
    logic [NODE_AW-1:0] raddr;
  } ram_req_t;

  // Conditioned configuration handed to the sequencer.
  typedef struct packed {
    logic             clear;
    logic [CAP_W-1:0] cap;
    logic [LVL_W-1:0] vcap_lg;
  } cfg_info_t;

  // Finished result offered by the sequencer.
  typedef struct packed {
    logic             valid;
    status_t          status;
    logic [OFF_W-1:0] block_offset;
  } result_t;

  // Smallest exponent e with 2**e >= x, for x of at least one.
  function automatic logic [LVL_W-1:0] clog2_ceil(input logic [CAP_W-1:0] x);
    logic [LVL_W-1:0] r;
    r = LVL_W'(CAP_W);
    for (int i = CAP_W; i >= 0; i--) begin
      if ((CAP_W+1)'(1) << i >= {1'b0, x}) begin
        r = LVL_W'(i);
      end
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/bba_if.sv @@
// Valid/ready channel interfaces for request and result words.
interface bba_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [bba_pkg::CAP_W-1:0]   request_size;
  logic [bba_pkg::OFF_W-1:0]   free_offset;

  modport source (output valid, output op, output request_size, output free_offset,
                  input ready);
  modport sink (input valid, input op, input request_size, input free_offset,
                output ready);
endinterface

interface bba_out_if;
  logic                         valid;
  logic                         ready;
  logic [bba_pkg::STATUS_W-1:0] status;
  logic [bba_pkg::OFF_W-1:0]    block_offset;

  modport source (output valid, output status, output block_offset, input ready);
  modport sink (input valid, input status, input block_offset, output ready);
endinterface

@@ hw/rtl/bba_node_ram.sv @@
// Node state memory: one write port and one registered read port.
module bba_node_ram (
  input  logic              clk,
  input  bba_pkg::ram_req_t req,
  output bba_pkg::node_st_t rdata
);

  bba_pkg::node_st_t mem [bba_pkg::NODE_DEPTH];
  bba_pkg::node_st_t rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Registered read port; a same-cycle write is not seen.
  always_ff @(posedge clk) begin
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/bba_ctrl.sv @@
// Sequencer that walks the node tree for allocate and free requests.
module bba_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  bba_in_if.sink             in_chan,
  input  bba_pkg::cfg_info_t cfg,
  output bba_pkg::ram_req_t  ram_req,
  input  bba_pkg::node_st_t  ram_rdata,
  output bba_pkg::result_t   res,
  input  logic               res_take
);

  localparam int AW = bba_pkg::NODE_AW;
  localparam int PW = bba_pkg::PROD_W;
  localparam int CW = bba_pkg::CAP_W;
  localparam int LW = bba_pkg::LVL_W;
  localparam int OW = bba_pkg::OFF_W;

  bba_pkg::ctl_state_t state_r, state_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;
  logic [AW-1:0]       ptr_r, ptr_nxt;
  logic [LW-1:0]       lvl_r, lvl_nxt;
  logic [CW-1:0]       left_r, left_nxt;
  logic [CW-1:0]       eff_r, eff_nxt;
  logic [LW-1:0]       size_lg_r, size_lg_nxt;
  logic [OW-1:0]       foff_r, foff_nxt;
  bba_pkg::status_t    status_r, status_nxt;
  logic [OW-1:0]       off_r, off_nxt;

  logic [AW-1:0] child_l, child_r, parent, buddy, par_buddy;
  logic [PW-1:0] alloc_off, alloc_end;
  logic          fit_fail;
  logic [LW-1:0] lvl_dn;
  logic [CW-1:0] half;
  logic [CW:0]   left_half;
  logic [CW-1:0] in_eff;
  logic [LW-1:0] in_size_lg;

  function automatic logic [AW-1:0] buddy_of(input logic [AW-1:0] n);
    return n[0] ? n + AW'(1) : n - AW'(1);
  endfunction

  // Tree arithmetic around the current node.
  assign child_l   = {ptr_r[AW-2:0], 1'b1};
  assign child_r   = child_l + AW'(1);
  assign parent    = AW'((ptr_r - AW'(1)) >> 1);
  assign buddy     = buddy_of(ptr_r);
  assign par_buddy = buddy_of(parent);

  // Block offset of the current node and the test against the real capacity.
  assign alloc_off = ((PW'(ptr_r) + PW'(1)) << lvl_r) - (PW'(1) << cfg.vcap_lg);
  assign alloc_end = alloc_off + PW'(eff_r);
  assign fit_fail  = alloc_end > PW'(cfg.cap);

  // Half span of the current node during a free descent.
  assign lvl_dn    = lvl_r - LW'(1);
  assign half      = CW'(1) << lvl_dn;
  assign left_half = {1'b0, left_r} + {1'b0, half};

  // Request size with zero taken as one, and its power-of-two exponent.
  assign in_eff     = (in_chan.request_size == '0) ? CW'(1) : in_chan.request_size;
  assign in_size_lg = bba_pkg::clog2_ceil(in_eff);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bba_pkg::CS_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk) begin
    ptr_r     <= ptr_nxt;
    lvl_r     <= lvl_nxt;
    left_r    <= left_nxt;
    eff_r     <= eff_nxt;
    size_lg_r <= size_lg_nxt;
    foff_r    <= foff_nxt;
    status_r  <= status_nxt;
    off_r     <= off_nxt;
  end

  // Next state, memory accesses and handshake.
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    ptr_nxt       = ptr_r;
    lvl_nxt       = lvl_r;
    left_nxt      = left_r;
    eff_nxt       = eff_r;
    size_lg_nxt   = size_lg_r;
    foff_nxt      = foff_r;
    status_nxt    = status_r;
    off_nxt       = off_r;
    ram_req.we    = 1'b0;
    ram_req.waddr = ptr_r;
    ram_req.wdata = bba_pkg::ND_UNUSED;
    ram_req.raddr = ptr_r;
    in_chan.ready = 1'b0;
    res.valid     = 1'b0;
    res.status    = status_r;
    res.block_offset = off_r;

    case (state_r)
      // Sweep the whole memory back to unused.
      bba_pkg::CS_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_r;
        ram_req.wdata = bba_pkg::ND_UNUSED;
        clr_nxt       = clr_r + AW'(1);
        if (&clr_r) begin
          state_nxt = bba_pkg::CS_IDLE;
        end
      end

      // Take a request and read the root.
      bba_pkg::CS_IDLE: begin
        in_chan.ready = 1'b1;
        ram_req.raddr = '0;
        if (in_chan.valid) begin
          ptr_nxt     = '0;
          lvl_nxt     = cfg.vcap_lg;
          left_nxt    = '0;
          eff_nxt     = in_eff;
          size_lg_nxt = in_size_lg;
          foff_nxt    = in_chan.free_offset;
          off_nxt     = '0;
          status_nxt  = bba_pkg::ST_OK;
          if (bba_pkg::op_t'(in_chan.op) == bba_pkg::OP_FREE) begin
            state_nxt = bba_pkg::CS_F_EVAL;
          end else if (in_size_lg > cfg.vcap_lg) begin
            status_nxt = bba_pkg::ST_NO_SPACE;
            state_nxt  = bba_pkg::CS_DONE;
          end else begin
            state_nxt = bba_pkg::CS_A_EVAL;
          end
        end
      end

      // Allocation: judge the node just read.
      bba_pkg::CS_A_EVAL: begin
        if (lvl_r == size_lg_r && ram_rdata == bba_pkg::ND_UNUSED) begin
          if (fit_fail) begin
            status_nxt = bba_pkg::ST_NO_SPACE;
            state_nxt  = bba_pkg::CS_DONE;
          end else begin
            ram_req.we    = 1'b1;
            ram_req.wdata = bba_pkg::ND_USED;
            off_nxt       = alloc_off[OW-1:0];
            if (ptr_r == '0) begin
              state_nxt = bba_pkg::CS_DONE;
            end else begin
              ram_req.raddr = buddy;
              state_nxt     = bba_pkg::CS_A_MARK;
            end
          end
        end else if (lvl_r != size_lg_r && ram_rdata == bba_pkg::ND_UNUSED) begin
          ram_req.we    = 1'b1;
          ram_req.wdata = bba_pkg::ND_SPLIT;
          state_nxt     = bba_pkg::CS_A_SPLIT_L;
        end else if (lvl_r != size_lg_r && ram_rdata == bba_pkg::ND_SPLIT) begin
          ptr_nxt       = child_l;
          lvl_nxt       = lvl_dn;
          ram_req.raddr = child_l;
        end else if (ptr_r[0]) begin
          // Left child that cannot serve: try its right sibling.
          ptr_nxt       = ptr_r + AW'(1);
          ram_req.raddr = ptr_r + AW'(1);
        end else begin
          state_nxt = bba_pkg::CS_A_UP;
        end
      end

      // A fresh split: both children start out unused.
      bba_pkg::CS_A_SPLIT_L: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = child_l;
        state_nxt     = bba_pkg::CS_A_SPLIT_R;
      end

      bba_pkg::CS_A_SPLIT_R: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = child_r;
        ram_req.raddr = child_l;
        ptr_nxt       = child_l;
        lvl_nxt       = lvl_dn;
        state_nxt     = bba_pkg::CS_A_EVAL;
      end

      // Backtrack one level until a right sibling is found.
      bba_pkg::CS_A_UP: begin
        if (ptr_r == '0) begin
          status_nxt = bba_pkg::ST_NO_SPACE;
          state_nxt  = bba_pkg::CS_DONE;
        end else begin
          lvl_nxt = lvl_r + LW'(1);
          if (parent[0]) begin
            ptr_nxt       = parent + AW'(1);
            ram_req.raddr = parent + AW'(1);
            state_nxt     = bba_pkg::CS_A_EVAL;
          end else begin
            ptr_nxt = parent;
          end
        end
      end

      // Mark ancestors full while the buddy just read is taken.
      bba_pkg::CS_A_MARK: begin
        if (ram_rdata == bba_pkg::ND_USED || ram_rdata == bba_pkg::ND_FULL) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = parent;
          ram_req.wdata = bba_pkg::ND_FULL;
          ptr_nxt       = parent;
          ram_req.raddr = par_buddy;
          if (parent == '0) begin
            state_nxt = bba_pkg::CS_DONE;
          end
        end else begin
          state_nxt = bba_pkg::CS_DONE;
        end
      end

      // Free: descend by offset to the used node.
      bba_pkg::CS_F_EVAL: begin
        if (ram_rdata == bba_pkg::ND_UNUSED) begin
          status_nxt = bba_pkg::ST_BAD_FREE;
          state_nxt  = bba_pkg::CS_DONE;
        end else if (ram_rdata == bba_pkg::ND_USED) begin
          if ({1'b0, foff_r} != left_r) begin
            status_nxt = bba_pkg::ST_BAD_FREE;
            state_nxt  = bba_pkg::CS_DONE;
          end else if (ptr_r == '0) begin
            ram_req.we = 1'b1;
            state_nxt  = bba_pkg::CS_DONE;
          end else begin
            ram_req.raddr = buddy;
            state_nxt     = bba_pkg::CS_F_MERGE;
          end
        end else if (lvl_r == '0) begin
          status_nxt = bba_pkg::ST_BAD_FREE;
          state_nxt  = bba_pkg::CS_DONE;
        end else begin
          lvl_nxt = lvl_dn;
          if ({1'b0, CW'(foff_r)} < left_half) begin
            ptr_nxt       = child_l;
            ram_req.raddr = child_l;
          end else begin
            left_nxt      = left_half[CW-1:0];
            ptr_nxt       = child_r;
            ram_req.raddr = child_r;
          end
        end
      end

      // Merge upward while the buddy just read is unused.
      bba_pkg::CS_F_MERGE: begin
        if (ram_rdata != bba_pkg::ND_UNUSED) begin
          ram_req.we = 1'b1;
          if (ptr_r == '0) begin
            state_nxt = bba_pkg::CS_DONE;
          end else begin
            ptr_nxt       = parent;
            ram_req.raddr = parent;
            state_nxt     = bba_pkg::CS_F_UP;
          end
        end else begin
          ptr_nxt = parent;
          if (parent == '0) begin
            ram_req.we    = 1'b1;
            ram_req.waddr = parent;
            state_nxt     = bba_pkg::CS_DONE;
          end else begin
            ram_req.raddr = par_buddy;
          end
        end
      end

      // Turn full ancestors back to split.
      bba_pkg::CS_F_UP: begin
        if (ram_rdata != bba_pkg::ND_FULL) begin
          state_nxt = bba_pkg::CS_DONE;
        end else begin
          ram_req.we    = 1'b1;
          ram_req.wdata = bba_pkg::ND_SPLIT;
          if (ptr_r == '0) begin
            state_nxt = bba_pkg::CS_DONE;
          end else begin
            ptr_nxt       = parent;
            ram_req.raddr = parent;
          end
        end
      end

      // Offer the result until the output register takes it.
      bba_pkg::CS_DONE: begin
        res.valid = 1'b1;
        if (status_r != bba_pkg::ST_OK) begin
          res.block_offset = '0;
        end
        if (res_take) begin
          state_nxt = bba_pkg::CS_IDLE;
        end
      end

      default: begin
        state_nxt = bba_pkg::CS_CLEAR;
        clr_nxt   = '0;
      end
    endcase

    // A capacity write starts a fresh tree.
    if (cfg.clear) begin
      state_nxt = bba_pkg::CS_CLEAR;
      clr_nxt   = '0;
    end
  end

endmodule

@@ hw/rtl/buddy_block_allocator_unit.sv @@
// Top level of the buddy block allocator: configuration, sequencer, node memory, output register.
//
// Requests arrive as words on in_chan (valid/ready): op 0 allocates a block of
// request_size units (zero counts as one), op 1 frees the block at free_offset.
// Each request yields one result word on out_chan with status (0 ok, 1 no space
// or too large, 2 invalid free) and block_offset, zero unless an allocation succeeds.
// cfg_we with cfg_wdata sets the real capacity (0 acts as 1, above 1024 saturates)
// and discards every live allocation.
// One request is in work at a time. The node memory gives one node read per cycle.
// An allocation of a size above the virtual capacity fails without a search; else it
// inspects nodes on its way down, splits unused nodes, backs out of occupied
// subtrees a level at a time and marks ancestors full, then hands off the result.
// A free descends level by level to the used node, merges upward while buddies are
// unused and turns full ancestors back to split.
// After reset and after every capacity write a clearing pass returns all 2048
// nodes to unused while in_chan.ready stays low.
// The output register lets the next request be taken while a result waits; a
// stalled receiver holds the result, and the next result waits behind it.
module buddy_block_allocator_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [bba_pkg::CAP_W-1:0] cfg_wdata,
  bba_in_if.sink                    in_chan,
  bba_out_if.source                 out_chan
);

  localparam int CW = bba_pkg::CAP_W;
  localparam int LW = bba_pkg::LVL_W;

  logic [CW-1:0]              cap_r;
  logic [LW-1:0]              vcap_lg_r;
  logic [CW-1:0]              cap_cond;
  bba_pkg::cfg_info_t         cfg;
  bba_pkg::ram_req_t          ram_req;
  bba_pkg::node_st_t          ram_rdata;
  bba_pkg::result_t           res;
  logic                       res_take;
  logic                       out_valid_r;
  logic [bba_pkg::STATUS_W-1:0] out_status_r;
  logic [bba_pkg::OFF_W-1:0]  out_off_r;

  // Capacity as written, held between 1 and the maximum.
  always_comb begin
    if (cfg_wdata == '0) begin
      cap_cond = CW'(1);
    end else if (cfg_wdata > CW'(bba_pkg::MAX_UNITS)) begin
      cap_cond = CW'(bba_pkg::MAX_UNITS);
    end else begin
      cap_cond = cfg_wdata;
    end
  end

  // Capacity register and its power-of-two exponent.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r     <= CW'(bba_pkg::MAX_UNITS);
      vcap_lg_r <= LW'(bba_pkg::MAX_LG);
    end else if (cfg_we) begin
      cap_r     <= cap_cond;
      vcap_lg_r <= bba_pkg::clog2_ceil(cap_cond);
    end
  end

  assign cfg.clear   = cfg_we;
  assign cfg.cap     = cap_r;
  assign cfg.vcap_lg = vcap_lg_r;

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cfg       (cfg),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .res       (res),
    .res_take  (res_take)
  );

  bba_node_ram u_node_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  // Output register: loads when empty or being drained.
  assign res_take = res.valid && (!out_valid_r || out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_status_r <= res.status;
      out_off_r    <= res.block_offset;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.block_offset = out_off_r;

endmodule

@@ hw/rtl/bba_checker.sv @@
// Port-level checker for the buddy block allocator and its bind to the top level.
`include "buddy_block_allocator_unit_macros.svh"

module bba_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         cfg_we,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [bba_pkg::STATUS_W-1:0] out_status,
  input logic [bba_pkg::OFF_W-1:0]    out_block_offset
);

  // A failed request never reports an offset.
  `BBA_ASSERT_NOW(a_fail_zero_off, out_valid && out_status != bba_pkg::ST_OK, out_block_offset == '0, "offset set on failed result")

  // Only one request is in work: ready drops right after an accept.
  `BBA_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "request taken while busy")

  // A capacity write starts the clearing pass, which blocks requests.
  `BBA_ASSERT_NEXT(a_clear_blocks, cfg_we, !in_ready, "request taken during clearing")

  // A stalled result word holds.
  `BBA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_block_offset), "stalled result changed")

endmodule

bind buddy_block_allocator_unit bba_checker u_bba_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .cfg_we           (cfg_we),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_status       (out_chan.status),
  .out_block_offset (out_chan.block_offset)
);
